FILE: rtl/core/i2cmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C mailbox package
// Types and fixed constants shared by the mailbox, its table memory and the
// testbench.
// ----------------------------------------------------------------------------
package i2cmb_pkg;

   localparam int ENTRY_W = 32;

   // command codes
   localparam logic CMD_PACK = 1'b0;
   localparam logic CMD_BUS  = 1'b1;

   // TWI status codes, low three bits masked off
   localparam logic [7:0] STATUS_MASK = 8'hF8;
   localparam logic [7:0] ST_SR_START = 8'h60;
   localparam logic [7:0] ST_SR_DATA  = 8'h80;
   localparam logic [7:0] ST_SR_STOP  = 8'hA0;
   localparam logic [7:0] ST_ST_START = 8'hA8;
   localparam logic [7:0] ST_ST_WROTE = 8'hB8;
   localparam logic [7:0] ST_ST_NACK  = 8'hC0;

   // a received word with all of these bits set is a name
   localparam logic [15:0] NAME_MASK = 16'hFFF0;

   // error flag bit positions
   localparam int ERR_BAD_STATUS = 0;
   localparam int ERR_OVERRUN    = 1;
   localparam int ERR_EARLY_NACK = 2;

   typedef struct packed {
      logic        command;
      logic [15:0] msg_name;
      logic [15:0] msg_value;
      logic        batch_start;
      logic        batch_end;
      logic [7:0]  bus_status;
      logic [7:0]  rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_load;
      logic        ack_enable;
      logic        bus_reset;
      logic        word_valid;
      logic [15:0] word_name;
      logic [15:0] word_value;
      logic        frame_done;
      logic [2:0]  error_flags;
      logic        dropped;
      logic        msg_ready;
   } rsp_payload_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage

FILE: rtl/core/i2cmb_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C mailbox channel
// Valid/ready channel carrying one payload; a request moves on valid & ready.
// ----------------------------------------------------------------------------
interface i2cmb_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/i2cmb_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C mailbox entry table
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cmb_table_ram
   import i2cmb_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  logic               clock,
   input  ram_ctl_type        ram_ctl,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] table_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_ctl.wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (ram_ctl.rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/i2c_slave_message_mailbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave message mailbox
// A bus request is taken in idle, which issues its table read, and
//   its response is registered in the bus state; a pack request scans 0 to
//   TABLE_ENTRIES entries, one per cycle through the table memory read port,
//   then commits. One request in flight; the next is taken the cycle after
//   the response is registered; the commit and bus states wait while the
//   output is full. Reset is synchronous and clears all control state; table
//   contents are not cleared; search and send use only those below the count.
// ----------------------------------------------------------------------------
module i2c_slave_message_mailbox
   import i2cmb_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8
) (
   input logic          clock,
   input logic          reset,
   i2cmb_chan_if.sink   req_chan,
   i2cmb_chan_if.source rsp_chan
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int LEN_W = CNT_W + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT,
      ST_BUS
   } state_type;

   state_type        state_ff, state_in;
   req_payload_type  item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             hit_ff, hit_in;
   logic [LEN_W-1:0] sp_ff, sp_in;
   logic             dw_ff, dw_in;
   logic             lws_ff, lws_in;
   logic [7:0]       held_ff, held_in;
   logic             phase_ff, phase_in;
   logic [15:0]      last_name_ff, last_name_in;
   logic [2:0]       err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   ram_ctl_type        ram_ctl;
   logic [IDX_W-1:0]   ram_waddr;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   logic             out_free;
   logic [7:0]       status;
   logic [7:0]       new_status;
   logic [CNT_W-1:0] count_eff;
   logic [CNT_W-1:0] scan_next;
   logic [LEN_W-1:0] len;
   logic [LEN_W+7:0] len_wide;
   logic [LEN_W-1:0] tb_idx;
   logic [LEN_W-1:0] new_idx;
   logic [LEN_W-1:0] new_ent;
   logic [LEN_W:0]   sp_plus;
   logic [7:0]       tb_byte;
   logic [15:0]      word;
   rsp_payload_type  res;

   i2cmb_table_ram #(
      .DEPTH (TABLE_ENTRIES),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign status     = item_ff.bus_status & STATUS_MASK;
   assign new_status = req_chan.data.bus_status & STATUS_MASK;
   assign scan_next  = scan_ff + CNT_W'(1);
   assign len        = dw_ff ? {count_ff, 2'b00} : '0;
   assign len_wide   = {8'd0, len};
   assign sp_plus    = {1'b0, sp_ff} + (LEN_W + 1)'(1);
   assign word       = {held_ff, item_ff.rx_byte};

   // table byte for the current transmit index; entry was read when the request was taken
   always_comb begin
      tb_idx  = (status == ST_ST_START) ? '0 : sp_ff;
      tb_byte = '0;
      if (tb_idx < len) begin
         case (tb_idx[1:0])
            2'd0:    tb_byte = ram_rdata[31:24];
            2'd1:    tb_byte = ram_rdata[23:16];
            2'd2:    tb_byte = ram_rdata[15:8];
            default: tb_byte = ram_rdata[7:0];
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      sp_in        = sp_ff;
      dw_in        = dw_ff;
      lws_in       = lws_ff;
      held_in      = held_ff;
      phase_in     = phase_ff;
      last_name_in = last_name_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      ram_ctl      = '0;
      ram_waddr    = '0;
      ram_raddr    = '0;
      ram_wdata    = {item_ff.msg_name, item_ff.msg_value};
      count_eff    = count_ff;
      new_idx      = '0;
      new_ent      = '0;
      res          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               item_in = req_chan.data;
               if (req_chan.data.command == CMD_PACK) begin
                  // new batch with nothing waiting starts an empty table
                  if (req_chan.data.batch_start && !dw_ff) begin
                     count_eff = '0;
                  end
                  count_in = count_eff;
                  scan_in  = '0;
                  hit_in   = 1'b0;
                  if (count_eff != '0) begin
                     ram_ctl.rd_en = 1'b1;
                     state_in      = ST_SEARCH;
                  end else begin
                     state_in = ST_COMMIT;
                  end
               end else begin
                  new_idx       = (new_status == ST_ST_START) ? '0 : sp_ff;
                  new_ent       = new_idx >> 2;
                  ram_ctl.rd_en = (new_ent < LEN_W'(TABLE_ENTRIES));
                  ram_raddr     = new_ent[IDX_W-1:0];
                  state_in      = ST_BUS;
               end
            end
         end

         ST_SEARCH: begin
            if (ram_rdata[31:16] == item_ff.msg_name) begin
               hit_in   = 1'b1;
               state_in = ST_COMMIT;
            end else if (scan_next == count_ff) begin
               state_in = ST_COMMIT;
            end else begin
               scan_in       = scan_next;
               ram_ctl.rd_en = 1'b1;
               ram_raddr     = scan_next[IDX_W-1:0];
            end
         end

         ST_COMMIT: begin
            if (out_free) begin
               if (hit_ff) begin
                  ram_ctl.wr_en = 1'b1;
                  ram_waddr     = scan_ff[IDX_W-1:0];
               end else if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
                  ram_ctl.wr_en = 1'b1;
                  ram_waddr     = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  res.dropped = 1'b1;
               end
               if (item_ff.batch_end) begin
                  dw_in = 1'b1;
               end
               res.word_name   = last_name_ff;
               res.error_flags = err_ff;
               res.msg_ready   = dw_in;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = res;
               state_in        = ST_IDLE;
            end
         end

         ST_BUS: begin
            if (out_free) begin
               case (status)
                  ST_SR_START: begin
                     phase_in       = 1'b0;
                     res.ack_enable = 1'b1;
                  end
                  ST_SR_DATA: begin
                     if (!phase_ff) begin
                        held_in  = item_ff.rx_byte;
                        phase_in = 1'b1;
                     end else begin
                        phase_in = 1'b0;
                        if ((word & NAME_MASK) == NAME_MASK) begin
                           last_name_in = word;
                        end else begin
                           res.word_valid = 1'b1;
                           res.word_value = word;
                        end
                     end
                     res.ack_enable = 1'b1;
                  end
                  ST_SR_STOP: begin
                     phase_in       = 1'b0;
                     res.frame_done = 1'b1;
                  end
                  ST_ST_START: begin
                     res.tx_load = 1'b1;
                     if (!lws_ff) begin
                        res.tx_byte = len_wide[7:0];
                     end else begin
                        res.tx_byte    = tb_byte;
                        sp_in          = LEN_W'(1);
                        res.ack_enable = 1'b1;
                     end
                  end
                  ST_ST_WROTE: begin
                     if (sp_plus < {1'b0, len}) begin
                        res.tx_byte    = tb_byte;
                        sp_in          = sp_plus[LEN_W-1:0];
                        res.tx_load    = 1'b1;
                        res.ack_enable = 1'b1;
                     end else if (sp_plus == {1'b0, len}) begin
                        res.tx_byte = tb_byte;
                        sp_in       = sp_plus[LEN_W-1:0];
                        res.tx_load = 1'b1;
                     end else begin
                        err_in[ERR_OVERRUN] = 1'b1;
                     end
                  end
                  ST_ST_NACK: begin
                     if (!lws_ff) begin
                        lws_in         = 1'b1;
                        res.ack_enable = 1'b1;
                     end else if (sp_ff == len) begin
                        lws_in         = 1'b0;
                        dw_in          = 1'b0;
                        res.ack_enable = 1'b1;
                     end else begin
                        err_in[ERR_EARLY_NACK] = 1'b1;
                     end
                  end
                  default: begin
                     err_in[ERR_BAD_STATUS] = 1'b1;
                     dw_in                  = 1'b0;
                     lws_in                 = 1'b0;
                     res.tx_load            = 1'b1;
                     res.bus_reset          = 1'b1;
                  end
               endcase
               res.word_name   = last_name_in;
               res.error_flags = err_in;
               res.msg_ready   = dw_in;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = res;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         hit_ff       <= 1'b0;
         sp_ff        <= '0;
         dw_ff        <= 1'b0;
         lws_ff       <= 1'b0;
         held_ff      <= '0;
         phase_ff     <= 1'b0;
         last_name_ff <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         hit_ff       <= hit_in;
         sp_ff        <= sp_in;
         dw_ff        <= dw_in;
         lws_ff       <= lws_in;
         held_ff      <= held_in;
         phase_ff     <= phase_in;
         last_name_ff <= last_name_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   // table writes happen only when the pack response is registered
   a_write_at_commit: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.wr_en |-> (state_ff == ST_COMMIT) && out_free && rsp_valid_in)
      else $error("table write outside pack commit");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (scan_ff < count_ff))
      else $error("search index past entry count");

endmodule

FILE: dv/i2c_slave_message_mailbox_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave message mailbox testbench
// Drives pack and bus requests through the request channel and checks every
// response against an in-bench mailbox predictor, field by field. Both sides
// idle at random; one phase stalls the response side long enough to back up
// the request side.
// ----------------------------------------------------------------------------
module i2c_slave_message_mailbox_tb;
   import i2cmb_pkg::*;

   localparam int TABLE_DEPTH = 8;
   localparam int TIDX_W      = $clog2(TABLE_DEPTH);
   localparam int TIMEOUT_NS  = 2_000_000;

   logic clock;
   logic reset;

   i2cmb_chan_if #(.payload_type(req_payload_type)) req_chan ();
   i2cmb_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   i2c_slave_message_mailbox #(
      .TABLE_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // predicted mailbox state
   logic [31:0] out_table [TABLE_DEPTH] = '{default: '0};
   logic [3:0]  out_count    = '0;
   logic [5:0]  send_ptr     = '0;
   logic        out_waiting  = 1'b0;
   logic        length_sent  = 1'b0;
   logic [7:0]  rx_high      = '0;
   logic        rx_phase     = 1'b0;
   logic [15:0] rx_last_name = '0;
   logic [2:0]  err_bits     = '0;

   rsp_payload_type responses_due [$];

   int  mismatch_count    = 0;
   int  requests_sent     = 0;
   int  responses_checked = 0;
   int  rsp_hold_cycles   = 0;
   bit  idling_on         = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout: %0d responses still due", responses_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int out_length();
      return out_waiting ? 4 * int'(out_count) : 0;
   endfunction

   function automatic logic [7:0] out_byte(input int idx);
      logic [31:0] e;
      logic [15:0] w;
      if (idx >= out_length() || (idx >> 2) >= TABLE_DEPTH) return 8'h00;
      e = out_table[TIDX_W'(idx >> 2)];
      w = ((idx % 4) < 2) ? e[31:16] : e[15:0];
      return idx[0] ? w[7:0] : w[15:8];
   endfunction

   function automatic logic store_message(input logic [15:0] name, input logic [15:0] value,
                                          input logic first, input logic last);
      int   i;
      logic hit;
      logic full_drop;
      hit = 1'b0;
      full_drop = 1'b0;
      if (first && !out_waiting) out_count = '0;
      for (i = 0; i < int'(out_count) && i < TABLE_DEPTH; i++) begin
         if (!hit && out_table[TIDX_W'(i)][31:16] == name) begin
            out_table[TIDX_W'(i)] = {name, value};
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (int'(out_count) < TABLE_DEPTH) begin
            out_table[TIDX_W'(out_count)] = {name, value};
            out_count++;
         end else begin
            full_drop = 1'b1;
         end
      end
      if (last) out_waiting = 1'b1;
      return full_drop;
   endfunction

   function automatic rsp_payload_type predict_mailbox_response(input req_payload_type r);
      rsp_payload_type p;
      logic [7:0]      st;
      logic [15:0]     word;
      int              len;
      p = '0;
      if (r.command == CMD_PACK) begin
         p.dropped = store_message(r.msg_name, r.msg_value, r.batch_start, r.batch_end);
      end else begin
         len = out_length();
         st = r.bus_status & STATUS_MASK;
         case (st)
            ST_SR_START: begin
               rx_phase = 1'b0;
               p.ack_enable = 1'b1;
            end
            ST_SR_DATA: begin
               if (!rx_phase) begin
                  rx_high = r.rx_byte;
                  rx_phase = 1'b1;
               end else begin
                  word = {rx_high, r.rx_byte};
                  rx_phase = 1'b0;
                  if ((word & NAME_MASK) == NAME_MASK) begin
                     rx_last_name = word;
                  end else begin
                     p.word_valid = 1'b1;
                     p.word_value = word;
                  end
               end
               p.ack_enable = 1'b1;
            end
            ST_SR_STOP: begin
               rx_phase = 1'b0;
               p.frame_done = 1'b1;
            end
            ST_ST_START: begin
               p.tx_load = 1'b1;
               if (!length_sent) begin
                  p.tx_byte = 8'(len);
               end else begin
                  p.tx_byte = out_byte(0);
                  send_ptr = 6'd1;
                  p.ack_enable = 1'b1;
               end
            end
            ST_ST_WROTE: begin
               if (int'(send_ptr) + 1 < len) begin
                  p.tx_byte = out_byte(int'(send_ptr));
                  send_ptr++;
                  p.tx_load = 1'b1;
                  p.ack_enable = 1'b1;
               end else if (int'(send_ptr) + 1 == len) begin
                  p.tx_byte = out_byte(int'(send_ptr));
                  send_ptr++;
                  p.tx_load = 1'b1;
               end else begin
                  err_bits[ERR_OVERRUN] = 1'b1;
               end
            end
            ST_ST_NACK: begin
               if (!length_sent) begin
                  length_sent = 1'b1;
                  p.ack_enable = 1'b1;
               end else if (int'(send_ptr) == len) begin
                  length_sent = 1'b0;
                  out_waiting = 1'b0;
                  p.ack_enable = 1'b1;
               end else begin
                  err_bits[ERR_EARLY_NACK] = 1'b1;
               end
            end
            default: begin
               err_bits[ERR_BAD_STATUS] = 1'b1;
               out_waiting = 1'b0;
               length_sent = 1'b0;
               p.tx_load = 1'b1;
               p.bus_reset = 1'b1;
            end
         endcase
      end
      p.word_name = rx_last_name;
      p.error_flags = err_bits;
      p.msg_ready = out_waiting;
      return p;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_response(input rsp_payload_type got);
      rsp_payload_type want;
      if (responses_due.size() == 0) begin
         $error("response with no request pending");
         mismatch_count++;
         return;
      end
      want = responses_due.pop_front();
      compare_field("tx_byte",     32'(want.tx_byte),     32'(got.tx_byte));
      compare_field("tx_load",     32'(want.tx_load),     32'(got.tx_load));
      compare_field("ack_enable",  32'(want.ack_enable),  32'(got.ack_enable));
      compare_field("bus_reset",   32'(want.bus_reset),   32'(got.bus_reset));
      compare_field("word_valid",  32'(want.word_valid),  32'(got.word_valid));
      compare_field("word_name",   32'(want.word_name),   32'(got.word_name));
      compare_field("word_value",  32'(want.word_value),  32'(got.word_value));
      compare_field("frame_done",  32'(want.frame_done),  32'(got.frame_done));
      compare_field("error_flags", 32'(want.error_flags), 32'(got.error_flags));
      compare_field("dropped",     32'(want.dropped),     32'(got.dropped));
      compare_field("msg_ready",   32'(want.msg_ready),   32'(got.msg_ready));
      responses_checked++;
   endfunction

   initial begin : rsp_receiver
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = idling_on ? $urandom_range(0, 3) : 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         check_response(rsp_chan.data);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // valid stays high after acceptance; the next request or a pause decides
   task automatic send_request(input req_payload_type r);
      int gap;
      gap = idling_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= r;
      do @(posedge clock); while (!req_chan.ready);
      responses_due.push_back(predict_mailbox_response(r));
      requests_sent++;
   endtask

   task automatic wait_for_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (responses_due.size() > 0);
   endtask

   task automatic send_pack(input logic [15:0] name, input logic [15:0] value,
                            input logic first, input logic last);
      req_payload_type r;
      r.command     = CMD_PACK;
      r.msg_name    = name;
      r.msg_value   = value;
      r.batch_start = first;
      r.batch_end   = last;
      r.bus_status  = 8'($urandom);
      r.rx_byte     = 8'($urandom);
      send_request(r);
   endtask

   // low three status bits are don't-care, so they are always randomized
   task automatic send_bus(input logic [7:0] status, input logic [7:0] rx);
      req_payload_type r;
      r.command     = CMD_BUS;
      r.msg_name    = 16'($urandom);
      r.msg_value   = 16'($urandom);
      r.batch_start = 1'($urandom);
      r.batch_end   = 1'($urandom);
      r.bus_status  = status | 8'($urandom_range(0, 7));
      r.rx_byte     = rx;
      send_request(r);
   endtask

   task automatic send_pack_batch();
      int          n;
      int          i;
      logic [15:0] name;
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
         // half the names come from a tiny set so overwrites are common
         name = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) * 16'h5555
                                              : 16'($urandom);
         send_pack(name, 16'($urandom),
                   (i == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 19) == 0,
                   i == n - 1 && $urandom_range(0, 9) != 0);
      end
   endtask

   task automatic send_table_read();
      int left;
      send_bus(ST_ST_START, 8'($urandom));
      if ($urandom_range(0, 9) != 0) send_bus(ST_ST_NACK, 8'($urandom));
      send_bus(ST_ST_START, 8'($urandom));
      left = 40;
      while (int'(send_ptr) < out_length() && left > 0) begin
         if ($urandom_range(0, 29) == 0) break;
         send_bus(ST_ST_WROTE, 8'($urandom));
         left--;
      end
      if ($urandom_range(0, 9) == 0) send_bus(ST_ST_WROTE, 8'($urandom));
      send_bus(ST_ST_NACK, 8'($urandom));
   endtask

   task automatic send_rx_frame();
      int          words;
      int          i;
      logic [15:0] w;
      send_bus(ST_SR_START, 8'($urandom));
      words = $urandom_range(0, 4);
      for (i = 0; i < words; i++) begin
         w = ($urandom_range(0, 2) == 0) ? (NAME_MASK | 16'($urandom_range(0, 15)))
                                         : 16'($urandom);
         send_bus(ST_SR_DATA, w[15:8]);
         send_bus(ST_SR_DATA, w[7:0]);
      end
      if ($urandom_range(0, 5) == 0) send_bus(ST_SR_DATA, 8'($urandom));
      if ($urandom_range(0, 7) != 0) send_bus(ST_SR_STOP, 8'($urandom));
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 1) == 0)
         send_bus(8'($urandom), 8'($urandom));
      else
         send_pack(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_receive_words();
      send_bus(ST_SR_START, 8'h00);
      send_bus(ST_SR_DATA, 8'h12);
      send_bus(ST_SR_DATA, 8'h34);   // value before any name pairs with zero
      send_bus(ST_SR_DATA, 8'hFF);
      send_bus(ST_SR_DATA, 8'hF0);   // name word
      send_bus(ST_SR_DATA, 8'hAB);   // half word, dropped by the stop
      send_bus(ST_SR_STOP, 8'hFF);
   endtask

   task automatic test_pack_and_read();
      send_pack(16'hFFFF, 16'h0000, 1'b1, 1'b0);
      send_pack(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      send_bus(ST_ST_START, 8'h00);  // length
      send_bus(ST_ST_NACK, 8'h00);
      send_bus(ST_ST_START, 8'h00);  // first table byte
      send_bus(ST_ST_WROTE, 8'h00);
      send_bus(ST_ST_WROTE, 8'h00);
      send_bus(ST_ST_WROTE, 8'h00);  // last byte, no ack
      send_bus(ST_ST_NACK, 8'h00);
      send_bus(ST_ST_WROTE, 8'h00);  // nothing left to send
   endtask

   task automatic test_special_statuses();
      send_pack(16'h1111, 16'h0001, 1'b1, 1'b0);
      send_pack(16'h2222, 16'h0002, 1'b1, 1'b0);  // restart clears the table
      send_pack(16'h2222, 16'h0003, 1'b0, 1'b1);  // unmarked merge
      send_bus(8'h88, 8'h00);
      send_pack(16'h3333, 16'h0004, 1'b1, 1'b1);
      send_bus(ST_ST_START, 8'h00);
      send_bus(ST_ST_NACK, 8'h00);
      send_bus(ST_ST_START, 8'h00);
      send_bus(ST_ST_NACK, 8'h00);                // nack before the data ran out
      send_bus(8'h00, 8'hFF);
      send_bus(8'hF8, 8'h00);
   endtask

   task automatic test_table_overflow();
      int          i;
      logic [15:0] names [10];
      send_bus(8'h00, 8'($urandom));  // bad status clears any waiting table
      for (i = 0; i < 10; i++) begin
         names[i] = {4'(i), 12'($urandom)};
         send_pack(names[i], 16'($urandom), i == 0, i == 9);
      end
      // table full and waiting: known names still update, new ones drop
      send_pack(names[$urandom_range(0, 7)], 16'($urandom), 1'b1, 1'b0);
      send_pack({4'hF, 12'($urandom)}, 16'($urandom), 1'b0, 1'b1);
      send_table_read();
   endtask

   task automatic test_random_traffic(input int count);
      int stop_at;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:       send_pack_batch();
            6, 7, 8, 9, 10, 11:     send_table_read();
            12, 13, 14, 15, 16:     send_rx_frame();
            default:                send_noise();
         endcase
      end
   endtask

   task automatic test_backpressure();
      int i;
      wait_for_responses();
      idling_on = 1'b0;
      rsp_hold_cycles = 100;
      for (i = 0; i < 12; i++) send_noise();
      wait_for_responses();
      idling_on = 1'b1;
   endtask

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_receive_words();
      test_pack_and_read();
      test_special_statuses();
      wait_for_responses();
      repeat (3) test_table_overflow();
      test_random_traffic(250);
      idling_on = 1'b0;
      test_random_traffic(100);
      idling_on = 1'b1;
      test_backpressure();
      test_random_traffic(200);

      wait_for_responses();
      repeat (20) @(posedge clock);
      $display("Checked %0d responses for %0d requests: receive frames, pack batches,",
               responses_checked, requests_sent);
      $display("table overflow, table reads, bad statuses, early nacks, output stalls.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/i2cmb_pkg.sv
rtl/core/i2cmb_chan_if.sv
rtl/core/i2cmb_table_ram.sv
rtl/core/i2c_slave_message_mailbox.sv
dv/i2c_slave_message_mailbox_tb.sv
